>>> hw/rtl/fsia_pkg.sv
// ----------------------------------------------------------------------------
// fsia_pkg
// Shared types, codes and helpers for the floor-semantics integer alu.
// ----------------------------------------------------------------------------
package fsia_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned CntW      = 6;   // 64 steps for the serial units

  localparam logic [63:0] WMask = {64{1'b1}} >> (64 - DataWidth);

  typedef enum logic [4:0] {
    OP_ADD      = 5'd0,
    OP_SUB      = 5'd1,
    OP_MUL      = 5'd2,
    OP_FLOORDIV = 5'd3,
    OP_MOD      = 5'd4,
    OP_POW      = 5'd5,
    OP_AND      = 5'd6,
    OP_OR       = 5'd7,
    OP_XOR      = 5'd8,
    OP_SHL      = 5'd9,
    OP_SHR      = 5'd10,
    OP_INVERT   = 5'd11,
    OP_EQ       = 5'd12,
    OP_NE       = 5'd13,
    OP_LT       = 5'd14,
    OP_LE       = 5'd15,
    OP_GT       = 5'd16,
    OP_GE       = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIV0      = 3'd1,
    ST_NEG_SHIFT = 3'd2,
    ST_BIG_SHIFT = 3'd3,
    ST_NEG_EXP   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MS_OPS,
    MS_ACC,
    MS_SQ
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_POW,
    S_POW_ACC,
    S_POW_SH,
    S_POW_SQ,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [63:0] lhs_value;
    logic signed [63:0] rhs_value;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     mul_init;
    mul_sel_e mul_sel;
    logic     mul_step;
    logic     div_init;
    logic     div_step;
    logic     exp_shift;
    logic     acc_from_mul;
    logic     base_from_mul;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [4:0] opcode;
    logic       b_zero;
    logic       b_neg;
    logic       exp_zero;
    logic       exp_bit0;
    logic       exp_more;
    logic       cnt_last;
  } stat_t;

  function automatic logic [63:0] sext(input logic [63:0] v);
    logic [63:0] m;
    m = v & WMask;
    if (m[DataWidth-1]) begin
      m = m | ~WMask;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/fsia_datapath.sv
// ----------------------------------------------------------------------------
// fsia_datapath
// Operand registers, serial shift-add multiplier, restoring divider,
// power accumulator and the result register.
// ----------------------------------------------------------------------------
module fsia_datapath import fsia_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_data_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output out_t  out_data_o
);

  logic [4:0]      op_q;
  logic [63:0]     a_q, b_q;
  logic [63:0]     prod_q, prod_d, mcand_q, mplier_q;
  logic [63:0]     rem_q, quo_q, dvs_q;
  logic [63:0]     base_q, exp_q, pacc_q;
  logic [CntW-1:0] cnt_q;
  out_t            out_q;

  logic [64:0] trial;
  logic [64:0] trial_sub;
  logic [63:0] rem_nx, quo_nx;

  assign prod_d    = prod_q + (mplier_q[0] ? mcand_q : 64'd0);
  assign trial     = {rem_q, quo_q[63]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign rem_nx    = trial_sub[64] ? trial[63:0] : trial_sub[63:0];
  assign quo_nx    = {quo_q[62:0], ~trial_sub[64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul_init || cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.mul_step || cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      a_q    <= sext(in_data_i.lhs_value);
      b_q    <= sext(in_data_i.rhs_value);
      base_q <= sext(in_data_i.lhs_value);
      exp_q  <= sext(in_data_i.rhs_value);
      pacc_q <= 64'd1;
    end else begin
      if (cmd_i.exp_shift) begin
        exp_q <= exp_q >> 1;
      end
      if (cmd_i.acc_from_mul) begin
        pacc_q <= prod_d;
      end
      if (cmd_i.base_from_mul) begin
        base_q <= prod_d;
      end
    end

    if (cmd_i.mul_init) begin
      prod_q <= '0;
      case (cmd_i.mul_sel)
        MS_OPS: begin
          mcand_q  <= a_q;
          mplier_q <= b_q;
        end
        MS_ACC: begin
          mcand_q  <= pacc_q;
          mplier_q <= base_q;
        end
        default: begin
          mcand_q  <= base_q;
          mplier_q <= base_q;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      prod_q   <= prod_d;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end

    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= a_q[63] ? 64'd0 - a_q : a_q;
      dvs_q <= b_q[63] ? 64'd0 - b_q : b_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
  end

  // final result selection
  logic [63:0] res, qt, rt, qfix, rfix;
  status_e     st;
  logic        differ;

  assign differ = a_q[63] ^ b_q[63];
  assign qt     = differ ? 64'd0 - quo_q : quo_q;
  assign rt     = a_q[63] ? 64'd0 - rem_q : rem_q;
  assign qfix   = (rt != 64'd0 && differ) ? qt - 64'd1 : qt;
  assign rfix   = (rt != 64'd0 && differ) ? rt + b_q : rt;

  always_comb begin
    res = '0;
    st  = ST_OK;
    case (op_q)
      OP_ADD:    res = a_q + b_q;
      OP_SUB:    res = a_q - b_q;
      OP_MUL:    res = prod_q;
      OP_FLOORDIV: begin
        if (b_q == 64'd0) st = ST_DIV0;
        else res = qfix;
      end
      OP_MOD: begin
        if (b_q == 64'd0) st = ST_DIV0;
        else res = rfix;
      end
      OP_POW: begin
        if (b_q[63]) st = ST_NEG_EXP;
        else res = pacc_q;
      end
      OP_AND:    res = a_q & b_q;
      OP_OR:     res = a_q | b_q;
      OP_XOR:    res = a_q ^ b_q;
      OP_SHL: begin
        if (b_q[63]) st = ST_NEG_SHIFT;
        else if (b_q >= 64'(DataWidth - 1)) st = ST_BIG_SHIFT;
        else res = a_q << b_q[5:0];
      end
      OP_SHR: begin
        if (b_q[63]) st = ST_NEG_SHIFT;
        else if (b_q >= 64'(DataWidth - 1)) res = {64{a_q[63]}};
        else res = 64'($signed(a_q) >>> b_q[5:0]);
      end
      OP_INVERT: res = ~a_q;
      OP_EQ:     res = {63'd0, a_q == b_q};
      OP_NE:     res = {63'd0, a_q != b_q};
      OP_LT:     res = {63'd0, $signed(a_q) <  $signed(b_q)};
      OP_LE:     res = {63'd0, $signed(a_q) <= $signed(b_q)};
      OP_GT:     res = {63'd0, $signed(a_q) >  $signed(b_q)};
      OP_GE:     res = {63'd0, $signed(a_q) >= $signed(b_q)};
      default:   res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.result_value <= (st == ST_OK) ? sext(res) : 64'd0;
      out_q.status       <= st;
    end
  end

  assign out_data_o = out_q;

  assign stat_o.opcode   = op_q;
  assign stat_o.b_zero   = (b_q == 64'd0);
  assign stat_o.b_neg    = b_q[63];
  assign stat_o.exp_zero = (exp_q == 64'd0);
  assign stat_o.exp_bit0 = exp_q[0];
  assign stat_o.exp_more = (exp_q[63:1] != 63'd0);
  assign stat_o.cnt_last = &cnt_q;

endmodule

>>> hw/rtl/fsia_ctrl.sv
// ----------------------------------------------------------------------------
// fsia_ctrl
// Sequencer for the alu: operand capture, serial unit runs, power rounds
// and the output handshake.
// ----------------------------------------------------------------------------
module fsia_ctrl import fsia_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MS_OPS;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.opcode)
          OP_MUL: begin
            cmd_o.mul_init = 1'b1;
            state_d        = S_MUL;
          end
          OP_FLOORDIV, OP_MOD: begin
            if (stat_i.b_zero) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.div_init = 1'b1;
              state_d        = S_DIV;
            end
          end
          OP_POW: state_d = stat_i.b_neg ? S_FINISH : S_POW;
          default: state_d = S_FINISH;
        endcase
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.cnt_last) state_d = S_FINISH;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.cnt_last) state_d = S_FINISH;
      end
      S_POW: begin
        if (stat_i.exp_zero) begin
          state_d = S_FINISH;
        end else if (stat_i.exp_bit0) begin
          cmd_o.mul_init = 1'b1;
          cmd_o.mul_sel  = MS_ACC;
          state_d        = S_POW_ACC;
        end else begin
          state_d = S_POW_SH;
        end
      end
      S_POW_ACC: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.acc_from_mul = 1'b1;
          state_d            = S_POW_SH;
        end
      end
      S_POW_SH: begin
        cmd_o.exp_shift = 1'b1;
        if (stat_i.exp_more) begin
          cmd_o.mul_init = 1'b1;
          cmd_o.mul_sel  = MS_SQ;
          state_d        = S_POW_SQ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_POW_SQ: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.base_from_mul = 1'b1;
          state_d             = S_POW;
        end
      end
      S_FINISH: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/floor_semantics_integer_alu.sv
// ----------------------------------------------------------------------------
// floor_semantics_integer_alu
// Signed 64-bit alu with floor division/modulo, power, shifts and compares.
// ----------------------------------------------------------------------------
// simple ops finish after decode; mul, floordiv and mod run one bit per cycle in
// the shift-add multiplier or restoring divider, and pow takes up to 63 rounds
// of up to two multiplies each on the same serial multiplier.
// words are handled one at a time; the next word is taken once the previous
// one sits in the output register. reset clears the sequencer and output valid.
module floor_semantics_integer_alu import fsia_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  fsia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fsia_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random words into the floor-semantics integer alu with
// random idling on both channels and checks every result against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import fsia_pkg::*;

  localparam int unsigned StallLimit = 40000;
  localparam logic [4:0]  OpFirstSpare = 5'd18;
  localparam logic [4:0]  OpLastSpare  = 5'd31;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] AllOnes = '1;
  localparam logic [63:0] ShiftEdge = 64'd63;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  in_t  word_q[$];
  out_t result_q[$];
  bit   in_taken;
  bit   idle_on;
  int   in_gap;
  int   out_gap;
  int   n_sent;
  int   n_done;
  int   n_errors;
  int   drain_at;
  int   quiet_cycles;
  int   op_hits[32];

  floor_semantics_integer_alu dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic out_t alu_predict(in_t w);
    logic [63:0] a, b, res, ma, mb, qm, rm, qt, rt, base, ex;
    logic        differ;
    status_e     st;
    out_t        o;
    a = w.lhs_value;
    b = w.rhs_value;
    res = '0;
    st = ST_OK;
    case (w.opcode)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: res = a * b;
      OP_FLOORDIV, OP_MOD: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          qm = ma / mb;
          rm = ma % mb;
          differ = a[63] ^ b[63];
          qt = differ ? -qm : qm;
          rt = a[63] ? -rm : rm;
          // floor rounding: nonzero remainder follows the divisor sign
          if (rt != 0 && differ) begin
            qt = qt - 1;
            rt = rt + b;
          end
          res = (w.opcode == OP_FLOORDIV) ? qt : rt;
        end
      end
      OP_POW: begin
        if (b[63]) begin
          st = ST_NEG_EXP;
        end else begin
          base = a;
          ex = b;
          res = 64'd1;
          while (ex != 0) begin
            if (ex[0]) res = res * base;
            ex = ex >> 1;
            if (ex != 0) base = base * base;
          end
        end
      end
      OP_AND: res = a & b;
      OP_OR:  res = a | b;
      OP_XOR: res = a ^ b;
      OP_SHL: begin
        if (b[63]) st = ST_NEG_SHIFT;
        else if (b >= ShiftEdge) st = ST_BIG_SHIFT;
        else res = a << b[5:0];
      end
      OP_SHR: begin
        if (b[63]) st = ST_NEG_SHIFT;
        else if (b >= ShiftEdge) res = {64{a[63]}};
        else res = $signed(a) >>> b[5:0];
      end
      OP_INVERT: res = ~a;
      OP_EQ: res = {63'd0, a == b};
      OP_NE: res = {63'd0, a != b};
      OP_LT: res = {63'd0, $signed(a) < $signed(b)};
      OP_LE: res = {63'd0, $signed(a) <= $signed(b)};
      OP_GT: res = {63'd0, $signed(a) > $signed(b)};
      OP_GE: res = {63'd0, $signed(a) >= $signed(b)};
      default: res = '0;
    endcase
    o.result_value = (st == ST_OK) ? res : '0;
    o.status = st;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on word %0d: %s", $realtime, n_done, what);
    n_errors++;
  endtask

  task automatic add_word(input logic [4:0] op, input logic [63:0] a, input logic [63:0] b);
    in_t w;
    w.opcode = op;
    w.lhs_value = a;
    w.rhs_value = b;
    word_q = {word_q, w};
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {{32{1'b0}}, $urandom};
      2: return 64'(signed'($urandom_range(0, 40)) - 20);
      3: begin
        case ($urandom_range(0, 3))
          0: return MinVal;
          1: return MaxVal;
          2: return AllOnes;
          default: return '0;
        endcase
      end
      default: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
    endcase
  endfunction

  task automatic add_random_word();
    logic [4:0]  op;
    logic [63:0] a, b;
    op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(OpFirstSpare, OpLastSpare))
                                      : 5'($urandom_range(OP_ADD, OP_GE));
    a = pick_operand();
    b = pick_operand();
    if (op == OP_POW) begin
      // keep most exponents short, the serial unit is slow on wide ones
      case ($urandom_range(0, 19))
        0: b = {1'b0, 31'($urandom), $urandom};
        1, 2: b = -64'($urandom_range(1, 100));
        default: b = 64'($urandom_range(0, 70));
      endcase
    end else if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 2) != 0) begin
      b = 64'($urandom_range(0, 70));
    end else if ((op == OP_FLOORDIV || op == OP_MOD) && $urandom_range(0, 9) == 0) begin
      b = '0;
    end
    add_word(op, a, b);
  endtask

  // input side: monitor at the rising edge, driver at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      result_q = {result_q, alu_predict(in_data_i)};
      op_hits[in_data_i.opcode]++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (n_sent == drain_at && result_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= word_q.pop_front();
        n_sent++;
        if (idle_on && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 9);
      end
    end
  end

  // output side: check each result word against the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = result_q.pop_front();
        if (out_data_o.result_value !== want.result_value)
          report_mismatch($sformatf("result_value %h, predicted %h",
                                    out_data_o.result_value, want.result_value));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    out_data_o.status, want.status));
      end
      n_done++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n_ops;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    in_taken = 1'b0;
    idle_on = 1'b1;
    in_gap = 0;
    out_gap = 0;
    n_sent = 0;
    n_done = 0;
    n_errors = 0;
    quiet_cycles = 0;
    drain_at = 600;

    add_word(OP_ADD, MaxVal, 64'd1);
    add_word(OP_SUB, MinVal, 64'd1);
    add_word(OP_MUL, MinVal, AllOnes);
    add_word(OP_FLOORDIV, -64'd7, 64'd2);
    add_word(OP_MOD, 64'd7, -64'd2);
    add_word(OP_FLOORDIV, MinVal, AllOnes);
    add_word(OP_MOD, MinVal, AllOnes);
    add_word(OP_FLOORDIV, 64'd5, '0);
    add_word(OP_MOD, MinVal, '0);
    add_word(OP_POW, '0, '0);
    add_word(OP_POW, -64'd3, 64'd5);
    add_word(OP_POW, 64'd3, MaxVal);
    add_word(OP_POW, 64'd2, AllOnes);
    add_word(OP_AND, AllOnes, 64'h5555_5555_5555_5555);
    add_word(OP_OR, MinVal, MaxVal);
    add_word(OP_XOR, AllOnes, MinVal);
    add_word(OP_SHL, 64'd1, 64'd62);
    add_word(OP_SHL, 64'd1, ShiftEdge);
    add_word(OP_SHL, 64'd1, MinVal);
    add_word(OP_SHR, MinVal, ShiftEdge);
    add_word(OP_SHR, MinVal, 64'd62);
    add_word(OP_SHR, MaxVal, AllOnes);
    add_word(OP_INVERT, MinVal, MaxVal);
    add_word(OpFirstSpare, MaxVal, MaxVal);
    add_word(OpLastSpare, AllOnes, AllOnes);
    for (logic [4:0] op = OP_EQ; op <= OP_GE; op++) begin
      add_word(op, MinVal, MaxVal);
      add_word(op, AllOnes, AllOnes);
    end
    repeat (1250) add_random_word();

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    wait (word_q.size() < 150);
    // last stretch runs at full rate on both sides
    idle_on = 1'b0;
    wait (word_q.size() == 0 && !in_valid_i);
    wait (result_q.size() == 0);
    repeat (80) @(posedge clk_i);

    n_ops = 0;
    foreach (op_hits[i]) if (op_hits[i] != 0) n_ops++;
    $display("covered %0d words over %0d distinct opcodes, %0d results checked",
             n_sent, n_ops, n_done);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
